// File: hdl/vgu_pkg.sv
package vgu_pkg;

    localparam int DataWidthDef   = 32;
    localparam int FracBitsDef    = 16;
    localparam int CordicStepsDef = 16;
    localparam int FieldW         = 32;
    localparam int MatDim         = 4;
    localparam int MatEntries     = 16;
    localparam int AtanCount      = 24;
    localparam int CordicQ        = 30;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    // function codes
    localparam logic [2:0] FN_LOAD  = 3'd0;
    localparam logic [2:0] FN_XFORM = 3'd1;
    localparam logic [2:0] FN_SCALE = 3'd2;
    localparam logic [2:0] FN_ADD   = 3'd3;
    localparam logic [2:0] FN_DOT   = 3'd4;
    localparam logic [2:0] FN_CROSS = 3'd5;
    localparam logic [2:0] FN_ROTX  = 3'd6;
    localparam logic [2:0] FN_ROTY  = 3'd7;

    // atan(2^-i), full turn = 2^32
    function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
        case (i)
            5'd0:  atan_lut = 34'sh020000000;
            5'd1:  atan_lut = 34'sh012E4051D;
            5'd2:  atan_lut = 34'sh009FB385B;
            5'd3:  atan_lut = 34'sh0051111D4;
            5'd4:  atan_lut = 34'sh0028B0D43;
            5'd5:  atan_lut = 34'sh00145D7E1;
            5'd6:  atan_lut = 34'sh000A2F61E;
            5'd7:  atan_lut = 34'sh000517C55;
            5'd8:  atan_lut = 34'sh00028BE53;
            5'd9:  atan_lut = 34'sh000145F2E;
            5'd10: atan_lut = 34'sh0000A2F98;
            5'd11: atan_lut = 34'sh0000517CC;
            5'd12: atan_lut = 34'sh000028BE6;
            5'd13: atan_lut = 34'sh0000145F3;
            5'd14: atan_lut = 34'sh00000A2F9;
            5'd15: atan_lut = 34'sh00000517C;
            5'd16: atan_lut = 34'sh0000028BE;
            5'd17: atan_lut = 34'sh00000145F;
            5'd18: atan_lut = 34'sh000000A2F;
            5'd19: atan_lut = 34'sh000000517;
            5'd20: atan_lut = 34'sh00000028B;
            5'd21: atan_lut = 34'sh000000145;
            5'd22: atan_lut = 34'sh0000000A2;
            5'd23: atan_lut = 34'sh000000051;
            default: atan_lut = '0;
        endcase
    endfunction

endpackage

// File: hdl/vgu_cordic.sv
module vgu_cordic #(
    parameter int FRAC_BITS    = vgu_pkg::FracBitsDef,
    parameter int CORDIC_STEPS = vgu_pkg::CordicStepsDef
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] angle,
    output logic               done,
    output logic signed [33:0] cos_out,
    output logic signed [33:0] sin_out
);
    import vgu_pkg::*;

    localparam int Steps = (CORDIC_STEPS < AtanCount) ? CORDIC_STEPS : AtanCount;
    localparam int Sh    = CordicQ - FRAC_BITS;
    localparam logic signed [33:0] Half = 34'sd1 <<< (Sh - 1);

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [4:0]         i_reg, i_next;
    logic               busy_reg, busy_next, neg_reg, neg_next, done_reg, done_next;
    logic signed [33:0] xs, ys, xr, yr;
    logic signed [16:0] ang_adj;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign xr = (x_reg + Half) >>> Sh;
    assign yr = (y_reg + Half) >>> Sh;
    assign cos_out = neg_reg ? -xr : xr;
    assign sin_out = neg_reg ? -yr : yr;
    assign done = done_reg;

    // one micro-rotation per cycle
    always_comb begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg; i_next = i_reg;
        busy_next = busy_reg; neg_next = neg_reg; done_next = 1'b0;
        ang_adj = 17'(angle);
        if (start) begin
            neg_next = 1'b0;
            if (angle > 16'sd16384) begin
                ang_adj = 17'(angle) - 17'sd32768; neg_next = 1'b1;
            end else if (angle < -16'sd16384) begin
                ang_adj = 17'(angle) + 17'sd32768; neg_next = 1'b1;
            end
            x_next = CordicGain; y_next = '0;
            z_next = 34'(ang_adj) <<< 16;
            i_next = '0; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - atan_lut(i_reg);
            end else begin
                x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + atan_lut(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(Steps - 1)) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        i_reg <= i_next; neg_reg <= neg_next;
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg)
        else $error("cordic done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn) busy_reg |-> !done_reg)
        else $error("cordic busy and done");
    assert property (@(posedge aclk) disable iff (!aresetn) start |=> busy_reg)
        else $error("cordic did not start");
endmodule

// File: hdl/vector_geometry_unit.sv
// Vector geometry unit: a Q16.16 homogeneous vector unit with a 4x4 matrix
// loaded one entry per request (func 0). One request is taken at a time and
// s_tready stays low until its result has been taken from m_. All products
// run through one shared 34x34 multiplier, one product per cycle, into a
// wide accumulator. A request passes through accept, its products, finish and
// output: transform takes 16 products, dot and scale 3, cross 6; rotations
// first wait for the CORDIC, which does one rotation per cycle, then take 4
// products; load and add go from accept straight to output.
// Sums are floored to FRAC_BITS and saturated to DATA_WIDTH.
module vector_geometry_unit #(
    parameter int DATA_WIDTH   = vgu_pkg::DataWidthDef,
    parameter int FRAC_BITS    = vgu_pkg::FracBitsDef,
    parameter int CORDIC_STEPS = vgu_pkg::CordicStepsDef
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[2:0] vx vy vz vw ux uy uz scale_factor turn_angle[16] entry_index[4]
    //   entry_value, from bit 0 up; 311 bits padded to 312
    input  logic [311:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rx ry rz rw dot_value, 32 bits each, from bit 0 up
    output logic [159:0] m_tdata
);
    import vgu_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_CORD = 3'd1, ST_MUL = 3'd2,
                           ST_FIN = 3'd3, ST_OUT = 3'd4;
    localparam int AccW = 72;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  fn_reg;
    logic signed [31:0] v_reg [4];
    logic signed [31:0] u_reg [3];
    logic signed [31:0] sf_reg;
    logic signed [31:0] r_reg [5];
    logic signed [33:0] c_reg, s_reg;
    logic [3:0]  k_reg, k_next;
    logic signed [AccW-1:0] acc_reg;
    logic signed [31:0] mat_mem [MatEntries];
    logic signed [31:0] mat_rd_reg;
    logic signed [33:0] op_a, op_b;
    logic signed [67:0] prod_reg;
    logic        pv_reg, last_reg;
    logic [2:0]  dst_reg;
    logic [3:0]  nterm;
    logic        cstart, cdone;
    logic signed [33:0] ccos, csin;
    logic signed [AccW-1:0] acc_sum, sat_in;
    logic signed [31:0] sat_out;

    vgu_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cstart), .angle(s_tdata[274:259]),
        .done(cdone), .cos_out(ccos), .sin_out(csin)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {r_reg[4], r_reg[3], r_reg[2], r_reg[1], r_reg[0]};
    assign cstart   = s_tvalid && s_tready && (s_tdata[2:0] == FN_ROTX ||
                      s_tdata[2:0] == FN_ROTY);

    // index of the last product per function (number of products minus one)
    always_comb begin
        case (fn_reg)
            FN_XFORM: nterm = 4'd15;
            FN_DOT:   nterm = 4'd2;
            FN_CROSS: nterm = 4'd5;
            FN_SCALE: nterm = 4'd2;
            default:  nterm = 4'd3;
        endcase
    end

    // operand select for product k
    always_comb begin
        op_a = '0; op_b = '0;
        case (fn_reg)
            FN_XFORM: begin op_a = 34'(v_reg[k_reg[1:0]]); op_b = 34'(mat_rd_reg); end
            FN_SCALE: begin op_a = 34'(v_reg[k_reg[1:0]]); op_b = 34'(sf_reg); end
            FN_DOT:   begin op_a = 34'(v_reg[k_reg[1:0]]); op_b = 34'(u_reg[k_reg[1:0]]); end
            FN_CROSS: begin
                case (k_reg)
                    4'd0: begin op_a = 34'(v_reg[1]); op_b = 34'(u_reg[2]); end
                    4'd1: begin op_a = 34'(v_reg[2]); op_b = -34'(u_reg[1]); end
                    4'd2: begin op_a = 34'(v_reg[2]); op_b = 34'(u_reg[0]); end
                    4'd3: begin op_a = 34'(v_reg[0]); op_b = -34'(u_reg[2]); end
                    4'd4: begin op_a = 34'(v_reg[0]); op_b = 34'(u_reg[1]); end
                    default: begin op_a = 34'(v_reg[1]); op_b = -34'(u_reg[0]); end
                endcase
            end
            FN_ROTX: begin
                case (k_reg[1:0])
                    2'd0: begin op_a = 34'(v_reg[1]); op_b = c_reg; end
                    2'd1: begin op_a = 34'(v_reg[2]); op_b = s_reg; end
                    2'd2: begin op_a = 34'(v_reg[1]); op_b = -s_reg; end
                    default: begin op_a = 34'(v_reg[2]); op_b = c_reg; end
                endcase
            end
            default: begin
                case (k_reg[1:0])
                    2'd0: begin op_a = 34'(v_reg[0]); op_b = c_reg; end
                    2'd1: begin op_a = 34'(v_reg[2]); op_b = -s_reg; end
                    2'd2: begin op_a = 34'(v_reg[0]); op_b = s_reg; end
                    default: begin op_a = 34'(v_reg[2]); op_b = c_reg; end
                endcase
            end
        endcase
    end

    // floor of the exact sum equals floor of summed parts, so accumulate exact
    assign acc_sum = acc_reg + AccW'(prod_reg);
    assign sat_in  = acc_sum >>> FRAC_BITS;
    always_comb begin
        if (sat_in > AccW'((72'sd1 <<< (DATA_WIDTH - 1)) - 72'sd1))
            sat_out = 32'((72'sd1 <<< (DATA_WIDTH - 1)) - 72'sd1);
        else if (sat_in < -AccW'(72'sd1 <<< (DATA_WIDTH - 1)))
            sat_out = 32'(-(72'sd1 <<< (DATA_WIDTH - 1)));
        else
            sat_out = 32'(sat_in);
    end

    // product destination and whether it closes a sum
    logic [2:0] dst_c;
    logic       last_c;
    always_comb begin
        dst_c = 3'd0; last_c = 1'b0;
        case (fn_reg)
            FN_XFORM: begin dst_c = 3'(k_reg[3:2]); last_c = (k_reg[1:0] == 2'd3); end
            FN_SCALE: begin dst_c = 3'(k_reg[1:0]); last_c = 1'b1; end
            FN_DOT:   begin dst_c = 3'd4; last_c = (k_reg == 4'd2); end
            FN_CROSS: begin dst_c = 3'(k_reg[3:1]); last_c = k_reg[0]; end
            FN_ROTX:  begin dst_c = k_reg[1] ? 3'd2 : 3'd1; last_c = k_reg[0]; end
            default:  begin dst_c = k_reg[1] ? 3'd2 : 3'd0; last_c = k_reg[0]; end
        endcase
    end

    // matrix address: M[r][c] is stored column-major at c*4+r; transform walks k = r*4+c
    logic [3:0] rd_addr;
    assign rd_addr = {k_next[1:0], k_next[3:2]};

    always_comb begin
        state_next = state_reg; k_next = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                k_next = '0;
                if (s_tvalid) begin
                    if (s_tdata[2:0] == FN_LOAD || s_tdata[2:0] == FN_ADD)
                        state_next = ST_OUT;
                    else if (cstart)
                        state_next = ST_CORD;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_CORD: if (cdone) state_next = ST_MUL;
            ST_MUL: begin
                k_next = k_reg + 4'd1;
                if (k_reg == nterm) state_next = ST_FIN;
            end
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; k_reg <= '0; pv_reg <= 1'b0;
        end else begin
            state_reg <= state_next; k_reg <= k_next;
            pv_reg <= (state_reg == ST_MUL);
        end
    end

    // matrix store: 16 entries cleared by reset, one read port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MatEntries; i++) mat_mem[i] <= '0;
        end else if (s_tvalid && s_tready && s_tdata[2:0] == FN_LOAD) begin
            mat_mem[s_tdata[278:275]] <= s_tdata[310:279];
        end
        mat_rd_reg <= mat_mem[rd_addr];
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            fn_reg <= s_tdata[2:0];
            v_reg[0] <= s_tdata[34:3];   v_reg[1] <= s_tdata[66:35];
            v_reg[2] <= s_tdata[98:67];  v_reg[3] <= s_tdata[130:99];
            u_reg[0] <= s_tdata[162:131]; u_reg[1] <= s_tdata[194:163];
            u_reg[2] <= s_tdata[226:195]; sf_reg <= s_tdata[258:227];
            r_reg[0] <= s_tdata[34:3];   r_reg[1] <= s_tdata[66:35];
            r_reg[2] <= s_tdata[98:67];
            r_reg[3] <= (s_tdata[2:0] == FN_CROSS) ? '0 : s_tdata[130:99];
            r_reg[4] <= '0;
            if (s_tdata[2:0] == FN_ADD) begin
                for (int i = 0; i < 3; i++) begin
                    logic signed [33:0] sm;
                    sm = 34'($signed(s_tdata[3+32*i +: 32])) +
                         34'($signed(s_tdata[131+32*i +: 32]));
                    if (sm > 34'((35'sd1 <<< (DATA_WIDTH - 1)) - 35'sd1) && DATA_WIDTH < 33)
                        r_reg[i] <= 32'((35'sd1 <<< (DATA_WIDTH - 1)) - 35'sd1);
                    else if (sm < -34'(35'sd1 <<< (DATA_WIDTH - 1)) && DATA_WIDTH < 33)
                        r_reg[i] <= 32'(-(35'sd1 <<< (DATA_WIDTH - 1)));
                    else
                        r_reg[i] <= 32'(sm);
                end
            end
            acc_reg <= '0;
        end else if (pv_reg) begin
            if (last_reg) begin
                r_reg[dst_reg] <= sat_out;
                acc_reg <= '0;
            end else begin
                acc_reg <= acc_sum;
            end
        end
        if (cdone) begin
            c_reg <= ccos; s_reg <= csin;
        end
        prod_reg <= op_a * op_b;
        dst_reg  <= dst_c;
        last_reg <= last_c;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) s_tready |-> !m_tvalid)
        else $error("ready while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> !pv_reg || last_reg)
        else $error("unfinished sum at finish");
endmodule
